/* rtl/core/gzhp_pkg.sv */
// ----------------------------------------------------------------------------
// gzhp_pkg
// Types, codes and constants shared by the gzip member header parser.
// ----------------------------------------------------------------------------
package gzhp_pkg;

	localparam int LIMIT_W = 17;
	localparam int XLEN_W  = 16;
	localparam int PADDR_W = 3;

	localparam logic [LIMIT_W-1:0] NAME_LIMIT_RST    = LIMIT_W'(1 << 10);
	localparam logic [LIMIT_W-1:0] COMMENT_LIMIT_RST = LIMIT_W'(1 << 16);

	// last fixed header byte index (the fixed header is ten bytes)
	localparam logic [LIMIT_W-1:0] HDR_LAST_IDX = LIMIT_W'(10 - 1);

	localparam logic [7:0] MAGIC0         = 8'h1F;
	localparam logic [7:0] MAGIC1         = 8'h8B;
	localparam logic [7:0] METHOD_DEFLATE = 8'd8;

	// flag bit positions
	localparam int F_HCRC    = 1;
	localparam int F_EXTRA   = 2;
	localparam int F_NAME    = 3;
	localparam int F_COMMENT = 4;

	// register indexes (paddr[2])
	localparam logic REG_NAME_LIMIT    = 1'b0;
	localparam logic REG_COMMENT_LIMIT = 1'b1;

	// result status codes
	localparam logic [2:0] ST_IGNORED = 3'd0;
	localparam logic [2:0] ST_BUSY    = 3'd1;
	localparam logic [2:0] ST_DONE    = 3'd2;
	localparam logic [2:0] ST_MAGIC   = 3'd3;
	localparam logic [2:0] ST_METHOD  = 3'd4;
	localparam logic [2:0] ST_TRUNC   = 3'd5;
	localparam logic [2:0] ST_LONG    = 3'd6;

	// text kinds
	localparam logic [1:0] TK_NONE    = 2'd0;
	localparam logic [1:0] TK_NAME    = 2'd1;
	localparam logic [1:0] TK_COMMENT = 2'd2;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_HDR     = 4'd1,
		PH_HDR_BAD = 4'd2,
		PH_XLEN0   = 4'd3,
		PH_XLEN1   = 4'd4,
		PH_XSKIP   = 4'd5,
		PH_NAME    = 4'd6,
		PH_COMMENT = 4'd7,
		PH_HCRC0   = 4'd8,
		PH_HCRC1   = 4'd9
	} phase_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] name_limit;
		logic [LIMIT_W-1:0] comment_limit;
	} cfg_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
		logic       new_header;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  text_kind;
		logic [7:0]  text_byte;
		logic [7:0]  method;
		logic [7:0]  flags;
		logic [31:0] mod_time;
		logic [7:0]  extra_flags;
		logic [7:0]  host_os;
	} result_t;

	// first section present after the one at 'from'; PH_IDLE when none is left
	function automatic phase_t next_section(phase_t from, logic [7:0] flg);
		phase_t nxt;
		nxt = PH_IDLE;
		if (from < PH_XLEN0 && flg[F_EXTRA]) begin
			nxt = PH_XLEN0;
		end else if (from < PH_NAME && flg[F_NAME]) begin
			nxt = PH_NAME;
		end else if (from < PH_COMMENT && flg[F_COMMENT]) begin
			nxt = PH_COMMENT;
		end else if (from < PH_HCRC0 && flg[F_HCRC]) begin
			nxt = PH_HCRC0;
		end
		return nxt;
	endfunction

endpackage

/* rtl/core/gzip_header_parser_unit.sv */
// ----------------------------------------------------------------------------
// gzip_header_parser_unit
// gzip member header parser: one stream byte in, one status/text result out.
//
//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------------------
//  input   | in_valid / in_ready       | in_byte, end_of_input, new_header
//  output  | out_valid / out_ready     | status, text_kind, text_byte, method,
//          |                           | flags, mod_time, extra_flags, host_os
//  config  | psel/penable/pwrite/pready| paddr, pwdata, prdata (APB)
//
// One byte per cycle sustained while out_ready stays high; each result passes
// through the input register, then step logic into the result register, before
// it is presented on the output channel.
// While a result waits on out_ready the input register takes one more byte,
// then in_ready drops until out_ready returns.
// Reset puts the parser idle and the limits to 1024 (name) and 65536 (comment).
// ----------------------------------------------------------------------------
module gzip_header_parser_unit import gzhp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               end_of_input,
	input  logic               new_header,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [1:0]         text_kind,
	output logic [7:0]         text_byte,
	output logic [7:0]         method,
	output logic [7:0]         flags,
	output logic [31:0]        mod_time,
	output logic [7:0]         extra_flags,
	output logic [7:0]         host_os,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t step_res;
	result_t res_s2;
	logic    valid_s2;
	logic    load_s2;

	gzhp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign load_s2  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.in_byte      <= in_byte;
			item_s1.end_of_input <= end_of_input;
			item_s1.new_header   <= new_header;
		end
	end

	gzhp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (load_s2),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) res_s2 <= step_res;
	end

	assign out_valid   = valid_s2;
	assign status      = res_s2.status;
	assign text_kind   = res_s2.text_kind;
	assign text_byte   = res_s2.text_byte;
	assign method      = res_s2.method;
	assign flags       = res_s2.flags;
	assign mod_time    = res_s2.mod_time;
	assign extra_flags = res_s2.extra_flags;
	assign host_os     = res_s2.host_os;

	// a stalled result must not be overwritten by the step stage
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |-> !load_s2)
		else $error("result register loaded while stalled");

	// an accepted byte while the result stage stalls is held in the input stage
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && valid_s2 && !out_ready |=> valid_s1)
		else $error("input transaction lost during output stall");

	// a loaded step always produces a result
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |=> valid_s2)
		else $error("step result not presented");

endmodule

/* rtl/core/gzhp_regs.sv */
// ----------------------------------------------------------------------------
// gzhp_regs
// APB register file holding the name and comment length limits.
// ----------------------------------------------------------------------------
module gzhp_regs import gzhp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [LIMIT_W-1:0] name_limit_q;
	logic [LIMIT_W-1:0] comment_limit_q;
	logic               wr_en;
	logic               reg_sel;

	// word-aligned map: the low address bits do not take part in decode
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_limit_q    <= NAME_LIMIT_RST;
			comment_limit_q <= COMMENT_LIMIT_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_NAME_LIMIT:    name_limit_q    <= pwdata[LIMIT_W-1:0];
				REG_COMMENT_LIMIT: comment_limit_q <= pwdata[LIMIT_W-1:0];
				default:           name_limit_q    <= name_limit_q;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_NAME_LIMIT:    prdata[LIMIT_W-1:0] = name_limit_q;
			REG_COMMENT_LIMIT: prdata[LIMIT_W-1:0] = comment_limit_q;
			default:           prdata = '0;
		endcase
	end

	assign cfg.name_limit    = name_limit_q;
	assign cfg.comment_limit = comment_limit_q;

endmodule

/* rtl/core/gzhp_parse.sv */
// ----------------------------------------------------------------------------
// gzhp_parse
// Header parser state and the single-byte step logic; state moves on step_en.
// ----------------------------------------------------------------------------
module gzhp_parse import gzhp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step_en,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	phase_t             phase_q, phase_d, eff_phase;
	logic [LIMIT_W-1:0] byte_count_q, count_d, eff_count;
	logic [XLEN_W-1:0]  extra_length_q, xlen_d, eff_xlen, xlen_full;
	logic [7:0]         flag_q, flag_d, eff_flag;
	logic [7:0]         method_q, method_d, eff_method;
	logic [31:0]        time_q, time_d, eff_time;
	logic [7:0]         xfl_q, xfl_d, eff_xfl;
	logic [7:0]         os_q, os_d, eff_os;

	logic [7:0]         b;
	logic               hdr_last;
	logic               magic_bad;
	phase_t             hdr_next, sec_after_x, sec_after_str;
	logic [LIMIT_W-1:0] xskip_cnt;
	logic               xskip_end;
	logic [LIMIT_W-1:0] lim_raw, lim_eff;
	logic               str_long;

	assign b = item.in_byte;

	// a new header wipes the captured fields before this byte is judged
	assign eff_phase  = item.new_header ? PH_HDR : phase_q;
	assign eff_count  = item.new_header ? '0 : byte_count_q;
	assign eff_xlen   = item.new_header ? '0 : extra_length_q;
	assign eff_flag   = item.new_header ? '0 : flag_q;
	assign eff_method = item.new_header ? '0 : method_q;
	assign eff_time   = item.new_header ? '0 : time_q;
	assign eff_xfl    = item.new_header ? '0 : xfl_q;
	assign eff_os     = item.new_header ? '0 : os_q;

	assign hdr_last  = eff_count >= HDR_LAST_IDX;
	assign magic_bad = (eff_count == LIMIT_W'(0) && b != MAGIC0) ||
	                   (eff_count == LIMIT_W'(1) && b != MAGIC1);
	assign hdr_next      = next_section(PH_HDR_BAD, eff_flag);
	assign sec_after_x   = next_section(PH_XLEN0, eff_flag);
	assign sec_after_str = next_section(eff_phase, eff_flag);

	assign xlen_full = {b, eff_xlen[7:0]};
	assign xskip_cnt = eff_count + LIMIT_W'(1);
	assign xskip_end = xskip_cnt >= {1'b0, eff_xlen};

	assign lim_raw  = (eff_phase == PH_NAME) ? cfg.name_limit : cfg.comment_limit;
	assign lim_eff  = (lim_raw == '0) ? LIMIT_W'(1) : lim_raw;
	assign str_long = ({1'b0, eff_count} + (LIMIT_W+1)'(1)) >= {1'b0, lim_eff};

	// next state
	always_comb begin
		phase_d  = eff_phase;
		count_d  = eff_count;
		xlen_d   = eff_xlen;
		flag_d   = eff_flag;
		method_d = eff_method;
		time_d   = eff_time;
		xfl_d    = eff_xfl;
		os_d     = eff_os;
		if (eff_phase != PH_IDLE && item.end_of_input) begin
			phase_d = PH_IDLE;
			count_d = '0;
		end else begin
			unique case (eff_phase)
				PH_HDR, PH_HDR_BAD: begin
					if (magic_bad) phase_d = PH_HDR_BAD;
					unique case (eff_count)
						LIMIT_W'(2): method_d = b;
						LIMIT_W'(3): flag_d = b;
						LIMIT_W'(4): time_d[7:0]   = eff_time[7:0] | b;
						LIMIT_W'(5): time_d[15:8]  = eff_time[15:8] | b;
						LIMIT_W'(6): time_d[23:16] = eff_time[23:16] | b;
						LIMIT_W'(7): time_d[31:24] = eff_time[31:24] | b;
						LIMIT_W'(8): xfl_d = b;
						LIMIT_W'(9): os_d = b;
						default:     method_d = eff_method;
					endcase
					count_d = eff_count + LIMIT_W'(1);
					if (hdr_last) begin
						count_d = '0;
						if (eff_phase == PH_HDR_BAD || eff_method != METHOD_DEFLATE) begin
							phase_d = PH_IDLE;
						end else begin
							phase_d = hdr_next;
						end
					end
				end
				PH_XLEN0: begin
					xlen_d  = {8'h00, b};
					phase_d = PH_XLEN1;
				end
				PH_XLEN1: begin
					xlen_d  = xlen_full;
					count_d = '0;
					phase_d = (xlen_full == '0) ? sec_after_x : PH_XSKIP;
				end
				PH_XSKIP: begin
					count_d = xskip_cnt;
					if (xskip_end) begin
						phase_d = sec_after_x;
						count_d = '0;
					end
				end
				PH_NAME, PH_COMMENT: begin
					if (b == 8'h00) begin
						phase_d = sec_after_str;
						count_d = '0;
					end else if (str_long) begin
						phase_d = PH_IDLE;
						count_d = '0;
					end else begin
						count_d = eff_count + LIMIT_W'(1);
					end
				end
				PH_HCRC0: phase_d = PH_HCRC1;
				PH_HCRC1: begin
					phase_d = PH_IDLE;
					count_d = '0;
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// result of this byte
	always_comb begin
		res.status    = ST_BUSY;
		res.text_kind = TK_NONE;
		res.text_byte = 8'h00;
		if (eff_phase == PH_IDLE) begin
			res.status = ST_IGNORED;
		end else if (item.end_of_input) begin
			res.status = ST_TRUNC;
		end else begin
			unique case (eff_phase)
				PH_HDR, PH_HDR_BAD: begin
					if (hdr_last) begin
						if (eff_phase == PH_HDR_BAD) res.status = ST_MAGIC;
						else if (eff_method != METHOD_DEFLATE) res.status = ST_METHOD;
						else res.status = (hdr_next == PH_IDLE) ? ST_DONE : ST_BUSY;
					end
				end
				PH_XLEN1: begin
					if (xlen_full == '0)
						res.status = (sec_after_x == PH_IDLE) ? ST_DONE : ST_BUSY;
				end
				PH_XSKIP: begin
					if (xskip_end)
						res.status = (sec_after_x == PH_IDLE) ? ST_DONE : ST_BUSY;
				end
				PH_NAME, PH_COMMENT: begin
					if (b == 8'h00) begin
						res.status = (sec_after_str == PH_IDLE) ? ST_DONE : ST_BUSY;
					end else if (str_long) begin
						res.status = ST_LONG;
					end else begin
						res.text_kind = (eff_phase == PH_NAME) ? TK_NAME : TK_COMMENT;
						res.text_byte = b;
					end
				end
				PH_XLEN0, PH_HCRC0: res.status = ST_BUSY;
				PH_HCRC1:           res.status = ST_DONE;
				default:            res.status = ST_IGNORED;
			endcase
		end
	end

	assign res.method      = method_d;
	assign res.flags       = flag_d;
	assign res.mod_time    = time_d;
	assign res.extra_flags = xfl_d;
	assign res.host_os     = os_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			byte_count_q   <= '0;
			extra_length_q <= '0;
			flag_q         <= '0;
			method_q       <= '0;
			time_q         <= '0;
			xfl_q          <= '0;
			os_q           <= '0;
		end else if (step_en) begin
			phase_q        <= phase_d;
			byte_count_q   <= count_d;
			extra_length_q <= xlen_d;
			flag_q         <= flag_d;
			method_q       <= method_d;
			time_q         <= time_d;
			xfl_q          <= xfl_d;
			os_q           <= os_d;
		end
	end

	// any final status leaves the parser idle
	a_final_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.status != ST_BUSY |=> phase_q == PH_IDLE)
		else $error("parser not idle after a final status");

	// an emitted text byte always counts toward the string length
	a_text_counts: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.text_kind != TK_NONE |=> byte_count_q != '0)
		else $error("text byte emitted without count advance");

	// state holds between steps
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(phase_q) && $stable(byte_count_q) && $stable(time_q))
		else $error("parser state moved without a step");

endmodule
